// ----- design/flv_pkg.sv -----
`timescale 1ns / 1ps

package flv_pkg;

  // Phase codes of the token scanner
  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_INT     = 3'd1;
  localparam logic [2:0] PH_FRAC    = 3'd2;
  localparam logic [2:0] PH_EXPSIGN = 3'd3;
  localparam logic [2:0] PH_EXP     = 3'd4;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPPE  = 8'h45;
  localparam logic [7:0] CH_LOWE  = 8'h65;

  // Scanner state carried from one character to the next
  typedef struct packed {
    logic [2:0] phase;
    logic       int_seen;
    logic       frac_seen;
    logic       exp_seen;
    logic       latched;
    logic       verdict;
  } flv_state_t;

  localparam flv_state_t STATE_RESET = '{
    phase:     PH_START,
    int_seen:  1'b0,
    frac_seen: 1'b0,
    exp_seen:  1'b0,
    latched:   1'b0,
    verdict:   1'b0
  };

endpackage

// ----- design/flv_step.sv -----
`timescale 1ns / 1ps

module flv_step import flv_pkg::*; (
  input  flv_state_t state_i,
  input  logic [7:0] char_i,
  input  logic       last_i,
  output flv_state_t state_o,
  output logic       verdict_o
);

  flv_state_t st;
  flv_state_t cons;
  logic       digit;
  logic       expch;
  logic       skip;
  logic       mant_ok;
  logic       end_v;

  // Classify the character and advance the scanner by one step
  always_comb begin
    digit   = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
    expch   = (char_i == CH_LOWE) || (char_i == CH_UPPE);
    mant_ok = state_i.int_seen | state_i.frac_seen;
    st      = state_i;
    skip    = 1'b0;

    // Leave the start phase; a leading minus is swallowed
    if (!(st.phase inside {PH_INT, PH_FRAC, PH_EXPSIGN, PH_EXP})) begin
      st.phase = PH_INT;
      skip     = (char_i == CH_MINUS);
    end
    // Optional minus right after the exponent marker
    if (!skip && (st.phase == PH_EXPSIGN)) begin
      st.phase = PH_EXP;
      skip     = (char_i == CH_MINUS);
    end

    if (!skip) begin
      case (st.phase)
        PH_INT: begin
          if (char_i == CH_NUL) begin
            st.latched = 1'b1;
            st.verdict = st.int_seen;
          end else if (char_i == CH_DOT) begin
            st.phase = PH_FRAC;
          end else if (expch) begin
            if (!st.int_seen) begin
              st.latched = 1'b1;
              st.verdict = 1'b0;
            end else begin
              st.phase = PH_EXPSIGN;
            end
          end else if (digit) begin
            st.int_seen = 1'b1;
          end else begin
            st.latched = 1'b1;
            st.verdict = 1'b0;
          end
        end
        PH_FRAC: begin
          if (char_i == CH_NUL) begin
            st.latched = 1'b1;
            st.verdict = mant_ok;
          end else if (expch) begin
            if (!mant_ok) begin
              st.latched = 1'b1;
              st.verdict = 1'b0;
            end else begin
              st.phase = PH_EXPSIGN;
            end
          end else if (digit) begin
            st.frac_seen = 1'b1;
          end else begin
            st.latched = 1'b1;
            st.verdict = 1'b0;
          end
        end
        default: begin
          if (digit) begin
            st.exp_seen = 1'b1;
          end else if (char_i == CH_NUL) begin
            st.latched = 1'b1;
            st.verdict = st.exp_seen & mant_ok;
          end else begin
            st.latched = 1'b1;
            st.verdict = 1'b0;
          end
        end
      endcase
    end

    // A latched verdict freezes the scanner
    cons = state_i.latched ? state_i : st;

    // Verdict of the token as it stands
    case (cons.phase)
      PH_INT:               end_v = cons.int_seen;
      PH_FRAC:              end_v = cons.int_seen | cons.frac_seen;
      PH_EXPSIGN, PH_EXP:   end_v = cons.exp_seen & (cons.int_seen | cons.frac_seen);
      default:              end_v = 1'b0;
    endcase

    verdict_o = cons.latched ? cons.verdict : end_v;
    state_o   = last_i ? STATE_RESET : cons;
  end

endmodule

// ----- design/float_literal_validator_core.sv -----
`timescale 1ns / 1ps

// Decimal float literal checker.
// The slave stream carries one character per beat in s_axis_tdata; the
// beat with s_axis_tlast high is the final character of a token. For each
// token one result beat leaves on the master stream, bit 0 of m_axis_tdata
// high when the token is a valid literal: [-] [digits] [. [digits]]
// [(e|E) [-] digits], with at least one mantissa digit. No result is sent
// for other characters.
// The result of a token passes the input register, then the result
// register, before it is valid on the master side. Throughput: one
// character per clock while s_axis_tready is high; the scanner state is
// eight flip-flops updated by one short step of logic per character.
// Reset clears both register stages and puts the scanner in its start phase.
// When the receiver stalls, the result is held; characters keep flowing
// until a further last character finds the result register still full,
// and then s_axis_tready drops until the waiting beat is taken.
module float_literal_validator_core import flv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] char_code
  input  logic       s_axis_tlast,  // last_char
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata   // [0] is_float, [7:1] zero
);

  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_last_q;
  flv_state_t state_q;
  flv_state_t state_d;
  logic       verdict;
  logic       out_valid_q;
  logic       is_float_q;
  logic       out_free;
  logic       proc;

  // Stage handshake
  assign out_free      = !out_valid_q || m_axis_tready;
  assign proc          = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || proc;

  // Capture the incoming beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  flv_step u_step (
    .state_i   (state_q),
    .char_i    (in_char_q),
    .last_i    (in_last_q),
    .state_o   (state_d),
    .verdict_o (verdict)
  );

  // Advance the scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (proc) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= proc && in_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && in_last_q) begin
      is_float_q <= verdict;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, is_float_q};

  // A finished token sends the scanner back to its start phase
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && in_last_q |=> state_q == STATE_RESET)
    else $error("scanner not reset after last character");

  // A finished token always yields a result beat
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && in_last_q |=> m_axis_tvalid)
    else $error("last character produced no result");

  // A latched verdict holds until the token ends
  a_latch_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && !in_last_q && state_q.latched
    |=> state_q.latched && $stable(state_q.verdict))
    else $error("latched verdict changed inside a token");

  // No digit flag is set while still at the start phase
  a_start_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_START
    |-> !state_q.int_seen && !state_q.frac_seen && !state_q.exp_seen)
    else $error("digit flag set in start phase");

endmodule
